@@ design/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;
    localparam int ACTION_W   = 2;
    localparam int ITEM_W     = 32;
    localparam int RANK_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH    = 2'd0,
        ACT_POP     = 2'd1,
        ACT_READ    = 2'd2,
        ACT_REPLACE = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANK  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_SHIFT  = 2'd1,
        MODE_INSERT = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic              remove;
        logic [RANK_W-1:0] rank;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ design/spq_cell.sv @@
// One storage cell of the sorted chain: holds one entry, shifts or inserts.
`default_nettype none
module spq_cell #(
    parameter int DATA_WIDTH = spq_pkg::DATA_W_DEF,
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int IDX        = 0
) (
    input  wire                             i_clk,
    input  spq_pkg::t_cell_ctl              i_ctl,
    input  wire [DATA_WIDTH-1:0]            i_value,
    input  wire [$clog2(DEPTH+1)-1:0]       i_base_len,
    input  wire [DATA_WIDTH-1:0]            i_prev_e,
    input  wire [DATA_WIDTH-1:0]            i_next_e,
    input  wire                             i_prev_ge,
    output logic [DATA_WIDTH-1:0]           o_e,
    output logic                            o_ge
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > RANK_W) ? CW : RANK_W;

    logic [DATA_WIDTH-1:0] r_e;
    logic [DATA_WIDTH-1:0] n_e;
    logic [DATA_WIDTH-1:0] b_own;
    logic [DATA_WIDTH-1:0] b_prev;
    logic [IW-1:0]         idx_ext;
    logic [IW-1:0]         rank_ext;

    // b_own / b_prev: this and the previous slot after the optional removal
    always_comb begin
        idx_ext  = IW'(IDX);
        rank_ext = IW'(i_ctl.rank);
        b_own    = (i_ctl.remove && (idx_ext >= rank_ext)) ? i_next_e : r_e;
        b_prev   = (i_ctl.remove && (idx_ext > rank_ext)) ? r_e : i_prev_e;
        o_ge     = (idx_ext < IW'(i_base_len)) && (b_own >= i_value);
    end

    always_comb begin
        case (i_ctl.mode)
            MODE_SHIFT:  n_e = b_own;
            MODE_INSERT: n_e = o_ge ? b_own : (i_prev_ge ? i_value : b_prev);
            default:     n_e = r_e;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

    assign o_e = r_e;

endmodule
`default_nettype wire

@@ design/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: request decode, cell chain, result register.
//
// Usage: a request word (i_action, i_item_value, i_rank) is taken on a clock
// edge where start is high and busy is low. busy never rises, so a request
// may be issued on every cycle.
// Actions: push inserts in descending order, pop returns the largest word,
// read returns the word at a rank, replace overwrites at a rank and re-sorts.
// Each request yields one result word (o_read_value, o_status, o_count),
// shown for exactly one cycle with o_done high, in the cycle after acceptance.
// Throughput: one request per cycle; every cell of the chain compares its
// entry with the request value and takes its own, its neighbour's or the new
// word in the same cycle, so no request needs more than one pass.
// Flagged requests (pop when empty, push when full, rank at or beyond the
// count) return zero data and leave the contents unchanged.
// Reset (i_rst_n low, synchronous) empties the queue and clears o_done; the
// entries themselves are not cleared. The receiver cannot stall results.
`default_nettype none
module sorted_priority_queue #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = spq_pkg::DATA_W_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire [spq_pkg::ACTION_W-1:0]    i_action,
    input  wire [spq_pkg::ITEM_W-1:0]      i_item_value,
    input  wire [spq_pkg::RANK_W-1:0]      i_rank,
    output logic                           o_done,
    output logic [spq_pkg::ITEM_W-1:0]     o_read_value,
    output logic [spq_pkg::STATUS_W-1:0]   o_status,
    output logic [spq_pkg::COUNT_W-1:0]    o_count
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int IW = (CW > RANK_W) ? CW : RANK_W;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_done;
    logic [DATA_WIDTH-1:0] r_rd;
    logic [DATA_WIDTH-1:0] n_rd;
    t_status               r_status;
    t_status               n_status;

    t_cell_ctl             ctl;
    logic [DATA_WIDTH-1:0] value;
    logic [CW-1:0]         base_len;
    logic                  rank_bad;

    logic [DATA_WIDTH-1:0] cell_e  [DEPTH];
    logic                  cell_ge [DEPTH];

    assign busy  = 1'b0;
    assign value = DATA_WIDTH'(i_item_value);

    always_comb begin
        ctl.mode   = MODE_HOLD;
        ctl.remove = 1'b0;
        ctl.rank   = i_rank;
        base_len   = r_count;
        n_count    = r_count;
        n_rd       = '0;
        n_status   = ST_OK;
        rank_bad   = IW'(i_rank) >= IW'(r_count);
        if (start) begin
            unique case (t_action'(i_action))
                ACT_PUSH: begin
                    if (r_count == CW'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        ctl.mode = MODE_INSERT;
                        n_count  = r_count + CW'(1);
                    end
                end
                ACT_POP: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        ctl.mode   = MODE_SHIFT;
                        ctl.remove = 1'b1;
                        ctl.rank   = '0;
                        n_rd       = cell_e[0];
                        n_count    = r_count - CW'(1);
                    end
                end
                ACT_READ: begin
                    if (rank_bad) begin
                        n_status = ST_RANK;
                    end else begin
                        n_rd = cell_e[AW'(i_rank)];
                    end
                end
                ACT_REPLACE: begin
                    if (rank_bad) begin
                        n_status = ST_RANK;
                    end else begin
                        ctl.mode   = MODE_INSERT;
                        ctl.remove = 1'b1;
                        base_len   = r_count - CW'(1);
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .DEPTH      (DEPTH),
            .IDX        (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_value    (value),
            .i_base_len (base_len),
            .i_prev_e   ((g == 0) ? '0 : cell_e[(g == 0) ? 0 : g - 1]),
            .i_next_e   ((g == DEPTH - 1) ? '0 : cell_e[(g == DEPTH - 1) ? g : g + 1]),
            .i_prev_ge  ((g == 0) ? 1'b1 : cell_ge[(g == 0) ? 0 : g - 1]),
            .o_e        (cell_e[g]),
            .o_ge       (cell_ge[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd     <= n_rd;
        r_status <= n_status;
    end

    assign o_done       = r_done;
    assign o_read_value = ITEM_W'(r_rd);
    assign o_status     = r_status;
    assign o_count      = COUNT_W'(r_count);

endmodule
`default_nettype wire
